// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pole cascade RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SNCP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SNCP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sncp_pkg.sv =====
// ----------------------------------------------------------------------------
// sncp_pkg
// Widths, register indexes and the multiplier request type of the cascade.
// ----------------------------------------------------------------------------
package sncp_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W    = 24;
    localparam int STATE_W     = 32;
    localparam int COEF_W      = 17;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int MUL_A_W     = 35;
    localparam int MUL_B_W     = 18;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // Unity in Q1.16.
    localparam int ONE_Q16 = 65536;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CUTOFF = 2'd0,
        REG_NONLIN = 2'd1,
        REG_STAGES = 2'd2,
        REG_MIX    = 2'd3
    } cfg_reg_t;

    // One request to the shared multiplier; both operands are two's complement.
    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

// ===== sv/sncp_mul.sv =====
// ----------------------------------------------------------------------------
// sncp_mul
// Shared signed multiplier with a registered product, one request per cycle.
// ----------------------------------------------------------------------------
module sncp_mul
    import sncp_pkg::*;
(
    input  logic                      aclk,
    input  mul_req_t                  req,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    // Full-precision signed product; the result always fits the product width.
    assign prod_next = $signed(req.a) * $signed(req.b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/stereo_nonlinear_pole_cascade.sv =====
// ----------------------------------------------------------------------------
// stereo_nonlinear_pole_cascade
// Stereo cascade of nonlinear one-pole stages with a dry/wet mix.
// ----------------------------------------------------------------------------
// One stereo pair is taken per transaction and both channels run through the
// active stages one after the other, each stage being eight steps of a small
// sequencer around a single 35 x 18 multiplier and one read and one write of
// the stage state memory. With S active stages (stage_count, limited to
// MAX_STAGES, eight after reset) s_tready stays low after an acceptance for
// the S stages of eight steps and three mix steps for each channel, then one
// step that moves the pair into the output register; only then is a new pair
// taken. A finished result waits in the output register, so the next pair is
// accepted while it is still unclaimed; should that result still be unclaimed
// when the next one is done, the block holds in its output step until the
// sink takes it. The state memory needs no clearing pass: a valid flag per
// entry, cleared by reset, makes an unwritten entry read as zero.
// Configuration must only be written while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_nonlinear_pole_cascade
    import sncp_pkg::*;
#(
    parameter int MAX_STAGES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input pair
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*SAMPLE_W-1:0]  s_tdata,    // left_sample, right_sample
    // Result pair
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*SAMPLE_W-1:0]  m_tdata,    // left_out, right_out
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]      cfg_wdata
);

    localparam int MEM_DEPTH = 2 * MAX_STAGES;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(MAX_STAGES + 1);

    localparam int SLEW_SHIFT  = 17;
    localparam int LEVEL_SHIFT = 16;

    localparam logic signed [MUL_P_W-1:0] SLEW_HALF  = MUL_P_W'(longint'(1) << (SLEW_SHIFT - 1));
    localparam logic signed [MUL_P_W-1:0] LEVEL_HALF = MUL_P_W'(longint'(1) << (LEVEL_SHIFT - 1));
    localparam logic signed [MUL_P_W-1:0] P_ONE      = MUL_P_W'(ONE_Q16);
    localparam logic signed [MUL_P_W-1:0] STATE_MAX  = MUL_P_W'((longint'(1) << (STATE_W - 1)) - 1);
    localparam logic signed [MUL_P_W-1:0] STATE_MIN  = -STATE_MAX - MUL_P_W'(1);
    localparam logic signed [MUL_P_W-1:0] SAMPLE_MAX = MUL_P_W'((longint'(1) << (SAMPLE_W - 1)) - 1);
    localparam logic signed [MUL_P_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - MUL_P_W'(1);

    localparam logic [COEF_W-1:0] CUTOFF_FLOOR = COEF_W'(7);
    localparam logic [COEF_W-1:0] COEF_ONE     = COEF_W'(ONE_Q16);

    // Sequencer states, one-hot.
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_READ   = 13'b0000000000010,
        ST_MUL_T  = 13'b0000000000100,
        ST_MUL_P  = 13'b0000000001000,
        ST_DI     = 13'b0000000010000,
        ST_MUL_S  = 13'b0000000100000,
        ST_MUL_L1 = 13'b0000001000000,
        ST_MUL_L2 = 13'b0000010000000,
        ST_WRITE  = 13'b0000100000000,
        ST_MIX_Y  = 13'b0001000000000,
        ST_MIX_X  = 13'b0010000000000,
        ST_MIX_R  = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } seq_state_t;

    // Saturate a wide value to the stage state width.
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [MUL_P_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > STATE_MAX) begin
            r = STATE_MAX[STATE_W-1:0];
        end else if (v < STATE_MIN) begin
            r = STATE_MIN[STATE_W-1:0];
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    // Saturate a wide value to the sample width.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [MUL_P_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAMPLE_MAX) begin
            r = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (v < SAMPLE_MIN) begin
            r = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [COEF_W-1:0]  cutoff_coef_reg;
    logic [COEF_W-1:0]  nonlin_coef_reg;
    logic [COUNT_W-1:0] stage_count_reg;
    logic [COEF_W-1:0]  mix_control_reg;

    // Sequencer and datapath registers
    seq_state_t                state_reg;
    seq_state_t                state_next;
    logic                      chan_reg;
    logic [CNT_W-1:0]          stage_reg;
    logic signed [STATE_W-1:0] y_reg;
    logic [SAMPLE_W-1:0]       in_left_reg;
    logic [SAMPLE_W-1:0]       in_right_reg;
    logic signed [STATE_W-1:0] lvl_reg;
    logic signed [STATE_W-1:0] slw_reg;
    logic [COEF_W-1:0]         di_reg;
    logic signed [STATE_W-1:0] slw_new_reg;
    logic signed [MUL_P_W-1:0] acc_reg;
    logic [SAMPLE_W-1:0]       left_res_reg;
    logic [SAMPLE_W-1:0]       right_res_reg;
    logic                      m_tvalid_reg;
    logic [2*SAMPLE_W-1:0]     m_tdata_reg;

    // State memory: level in the upper half, slew in the lower half
    logic [2*STATE_W-1:0] state_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [2*STATE_W-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     mem_addr;

    // Shared multiplier
    mul_req_t                  mul_req;
    logic signed [MUL_P_W-1:0] prod;

    // Effective settings
    logic [COEF_W-1:0]         f_eff;
    logic [COEF_W-1:0]         n_eff;
    logic [COEF_W-1:0]         d_eff;
    logic [CNT_W-1:0]          stages_act;
    logic signed [COEF_W+1:0]  wet_wide;
    logic signed [COEF_W+1:0]  dry_wide;
    logic signed [MUL_B_W-1:0] wet;
    logic signed [MUL_B_W-1:0] dry;

    // Stage arithmetic
    logic signed [MUL_P_W-1:0] t_full;
    logic [MUL_P_W-1:0]        abs_p;
    logic [MUL_P_W-17:0]       di_q;
    logic [COEF_W-1:0]         di_next;
    logic signed [STATE_W+1:0] x_minus_lvl;
    logic signed [STATE_W:0]   lvl_plus_slw;
    logic [MUL_B_W-1:0]        one_minus_di;
    logic signed [MUL_P_W-1:0] slew_rnd;
    logic signed [MUL_P_W-1:0] sum_rnd;
    logic signed [STATE_W-1:0] level_new;
    logic signed [SAMPLE_W-1:0] mix_res;
    logic signed [STATE_W-1:0] dry_x;
    logic                      last_stage;
    logic                      s_accept;
    logic                      out_free;

    sncp_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // Clamp the register values to their working ranges.
    always_comb begin
        if (cutoff_coef_reg < CUTOFF_FLOOR) begin
            f_eff = CUTOFF_FLOOR;
        end else if (cutoff_coef_reg > COEF_ONE) begin
            f_eff = COEF_ONE;
        end else begin
            f_eff = cutoff_coef_reg;
        end
        n_eff = (nonlin_coef_reg > COEF_ONE) ? COEF_ONE : nonlin_coef_reg;
        d_eff = (mix_control_reg > COEF_ONE) ? COEF_ONE : mix_control_reg;
        if (32'(stage_count_reg) > 32'(MAX_STAGES)) begin
            stages_act = CNT_W'(MAX_STAGES);
        end else begin
            stages_act = CNT_W'(stage_count_reg);
        end
    end

    // Mix gains: wet is 2D - 1, dry is 2 - 2D limited to unity.
    assign wet_wide = $signed({2'b00, d_eff} <<< 1) - $signed((COEF_W+2)'(ONE_Q16));
    assign dry_wide = $signed((COEF_W+2)'(2 * ONE_Q16)) - $signed({2'b00, d_eff} <<< 1);
    assign wet      = wet_wide[MUL_B_W-1:0];
    assign dry      = (dry_wide > $signed((COEF_W+2)'(ONE_Q16))) ? MUL_B_W'(ONE_Q16)
                                                                  : dry_wide[MUL_B_W-1:0];

    // Nonlinear term from the product x * n.
    assign t_full = (prod >>> 23) + P_ONE;

    // Coefficient magnitude from f * t, limited to unity.
    assign abs_p   = prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);
    assign di_q    = abs_p[MUL_P_W-1:16];
    assign di_next = (di_q > (MUL_P_W-16)'(ONE_Q16)) ? COEF_ONE : di_q[COEF_W-1:0];

    // Operand sums for the slew and level products.
    assign x_minus_lvl  = (STATE_W+2)'(y_reg) - (STATE_W+2)'(lvl_reg) + (STATE_W+2)'(slw_reg);
    assign lvl_plus_slw = (STATE_W+1)'(lvl_reg) + (STATE_W+1)'(slw_reg);
    assign one_minus_di = MUL_B_W'(ONE_Q16) - MUL_B_W'(di_reg);

    // Rounded results; the accumulator already holds the rounding half.
    assign slew_rnd  = (prod + SLEW_HALF) >>> SLEW_SHIFT;
    assign sum_rnd   = (acc_reg + prod) >>> LEVEL_SHIFT;
    assign level_new = sat_state(sum_rnd);
    assign mix_res   = sat_sample(sum_rnd);

    assign dry_x = chan_reg ? STATE_W'($signed(in_right_reg)) : STATE_W'($signed(in_left_reg));

    // Multiplier operand selection per sequencer step.
    always_comb begin
        mul_req = '0;
        unique case (state_reg)
            ST_MUL_T: begin
                mul_req.a = MUL_A_W'(y_reg);
                mul_req.b = MUL_B_W'(n_eff);
            end
            ST_MUL_P: begin
                mul_req.a = t_full[MUL_A_W-1:0];
                mul_req.b = MUL_B_W'(f_eff);
            end
            ST_MUL_S: begin
                mul_req.a = MUL_A_W'(x_minus_lvl);
                mul_req.b = MUL_B_W'(di_reg);
            end
            ST_MUL_L1: begin
                mul_req.a = MUL_A_W'(y_reg);
                mul_req.b = MUL_B_W'(di_reg);
            end
            ST_MUL_L2: begin
                mul_req.a = MUL_A_W'(lvl_plus_slw);
                mul_req.b = one_minus_di;
            end
            ST_MIX_Y: begin
                mul_req.a = MUL_A_W'(y_reg);
                mul_req.b = wet;
            end
            ST_MIX_X: begin
                mul_req.a = MUL_A_W'(dry_x);
                mul_req.b = dry;
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    // The input is only offered while idle and out of reset.
    assign s_tready   = aresetn && (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign last_stage = ((stage_reg + CNT_W'(1)) == stages_act);
    assign mem_addr   = IDX_W'({stage_reg, chan_reg});

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (stages_act == '0) ? ST_MIX_Y : ST_READ;
                end
            end
            ST_READ:   state_next = ST_MUL_T;
            ST_MUL_T:  state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_DI;
            ST_DI:     state_next = ST_MUL_S;
            ST_MUL_S:  state_next = ST_MUL_L1;
            ST_MUL_L1: state_next = ST_MUL_L2;
            ST_MUL_L2: state_next = ST_WRITE;
            ST_WRITE:  state_next = last_stage ? ST_MIX_Y : ST_READ;
            ST_MIX_Y:  state_next = ST_MIX_X;
            ST_MIX_X:  state_next = ST_MIX_R;
            ST_MIX_R: begin
                if (chan_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = (stages_act == '0) ? ST_MIX_Y : ST_READ;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state, output valid and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            cutoff_coef_reg <= COEF_W'(16384);
            nonlin_coef_reg <= '0;
            stage_count_reg <= COUNT_W'(8);
            mix_control_reg <= COEF_ONE;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_CUTOFF: cutoff_coef_reg <= cfg_wdata;
                    REG_NONLIN: nonlin_coef_reg <= cfg_wdata;
                    REG_STAGES: stage_count_reg <= cfg_wdata[COUNT_W-1:0];
                    REG_MIX:    mix_control_reg <= cfg_wdata;
                endcase
            end
        end
    end

    // Datapath registers, updated step by step.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    in_left_reg  <= s_tdata[SAMPLE_W-1:0];
                    in_right_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    y_reg        <= STATE_W'($signed(s_tdata[SAMPLE_W-1:0]));
                    chan_reg     <= 1'b0;
                    stage_reg    <= '0;
                end
            end
            ST_MUL_T: begin
                lvl_reg <= rd_valid_reg ? rd_data_reg[2*STATE_W-1:STATE_W] : '0;
                slw_reg <= rd_valid_reg ? rd_data_reg[STATE_W-1:0] : '0;
            end
            ST_DI: begin
                di_reg <= di_next;
            end
            ST_MUL_L1: begin
                slw_new_reg <= sat_state(slew_rnd);
            end
            ST_MUL_L2: begin
                acc_reg <= prod + LEVEL_HALF;
            end
            ST_WRITE: begin
                y_reg     <= level_new;
                stage_reg <= stage_reg + CNT_W'(1);
            end
            ST_MIX_X: begin
                acc_reg <= prod + LEVEL_HALF;
            end
            ST_MIX_R: begin
                if (chan_reg) begin
                    right_res_reg <= mix_res;
                end else begin
                    left_res_reg <= mix_res;
                    chan_reg     <= 1'b1;
                    stage_reg    <= '0;
                    y_reg        <= STATE_W'($signed(in_right_reg));
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {right_res_reg, left_res_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // State memory: one registered read and one write port.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            state_mem[mem_addr] <= {level_new, slw_new_reg};
        end
        if (state_reg == ST_READ) begin
            rd_data_reg  <= state_mem[mem_addr];
            rd_valid_reg <= valid_reg[mem_addr];
        end
    end

    // Entry valid flags; an entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (state_reg == ST_WRITE) begin
            valid_reg[mem_addr] <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the sequencer.
    `SNCP_ASSERT_NXT(a_accept_starts_work, aclk, aresetn, s_tvalid && s_tready, (state_reg == ST_READ) || (state_reg == ST_MIX_Y), "accepted pair did not start a stage or the mix")
    `SNCP_ASSERT_NXT(a_result_held, aclk, aresetn, (state_reg == ST_OUT) && m_tvalid_reg && !m_tready, (state_reg == ST_OUT) && $stable(m_tdata_reg), "pending result overwritten")
    `SNCP_ASSERT_IMP(a_write_follows_level, aclk, aresetn, state_reg == ST_WRITE, $past(state_reg) == ST_MUL_L2, "state write out of sequence")

endmodule
